// ----- rtl/core/hrk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hrk_pkg;

	localparam int RATE_W = 19;
	localparam int MOTION_W = 16;
	localparam int CONF_W = 17;
	localparam int VAR_W = 32;
	localparam int RA_W = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MOTION_LOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOTION_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONF_GATE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_NOISE = 2'd3;

	localparam logic [MOTION_W-1:0] MOTION_LOW_RST = 16'd8500;
	localparam logic [MOTION_W-1:0] MOTION_HIGH_RST = 16'd11000;
	localparam logic [CONF_W-1:0] CONF_GATE_RST = 17'd19661;
	localparam logic [RA_W-1:0] ACCEL_NOISE_RST = 24'd272956;
	localparam logic [RATE_W-1:0] RATE_RST = 19'd65536;
	localparam logic [VAR_W-1:0] VAR_RST = 32'd1677722;

	// Process noise levels, Q8.24.
	localparam logic [VAR_W-1:0] Q_LOW = 32'd6711;
	localparam logic [VAR_W-1:0] Q_MID = 32'd41943;
	localparam logic [VAR_W-1:0] Q_HIGH = 32'd107374;

	localparam logic [23:0] DELTA_BASE = 24'd838861;
	localparam logic [23:0] DELTA_SPAN = 24'd13086228;
	localparam logic [CONF_W-1:0] CONF_ONE = 17'd65536;
	localparam logic [CONF_W-1:0] CONF_FLOOR = 17'd66;

	// Divider geometry for the gain divisions.
	localparam int DIVD_W = 64;
	localparam int DIVS_W = 36;

	// The optical noise is round(d25^2 / (2401 * 2^24)). The rounding
	// bias is added to the numerator, the low 24 bits are dropped, and the
	// division by 2401 is a multiply by ceil(2^45 / 2401), which is exact for
	// any 33-bit numerator. That reciprocal is 3 * 2^32 + RO_RECIP_LO.
	localparam logic [56:0] RO_BIAS = 57'(64'd2401 << 23);
	localparam logic [31:0] RO_RECIP_LO = 32'd1769147296;

	// Datapath operations.
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NONE = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD = 5'd1;
	localparam logic [OP_W-1:0] OP_PRED = 5'd2;
	localparam logic [OP_W-1:0] OP_MDELTA = 5'd3;
	localparam logic [OP_W-1:0] OP_DELTA = 5'd4;
	localparam logic [OP_W-1:0] OP_MSQ = 5'd5;
	localparam logic [OP_W-1:0] OP_MRO = 5'd6;
	localparam logic [OP_W-1:0] OP_CAP_RO = 5'd7;
	localparam logic [OP_W-1:0] OP_MWO = 5'd8;
	localparam logic [OP_W-1:0] OP_MWA = 5'd9;
	localparam logic [OP_W-1:0] OP_MWS = 5'd10;
	localparam logic [OP_W-1:0] OP_SUM = 5'd11;
	localparam logic [OP_W-1:0] OP_NORM = 5'd12;
	localparam logic [OP_W-1:0] OP_DIV_GO = 5'd13;
	localparam logic [OP_W-1:0] OP_CAP_GO = 5'd14;
	localparam logic [OP_W-1:0] OP_DIV_GA = 5'd15;
	localparam logic [OP_W-1:0] OP_CAP_GA = 5'd16;
	localparam logic [OP_W-1:0] OP_DIV_GS = 5'd17;
	localparam logic [OP_W-1:0] OP_CAP_GS = 5'd18;
	localparam logic [OP_W-1:0] OP_MGX = 5'd19;
	localparam logic [OP_W-1:0] OP_MGO = 5'd20;
	localparam logic [OP_W-1:0] OP_MGA = 5'd21;
	localparam logic [OP_W-1:0] OP_COMMIT = 5'd22;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic gate_ok;
		logic norm_done;
		logic det_zero;
		logic div_busy;
	} sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/hrk_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface hrk_in_if;
	logic valid;
	logic ready;
	logic [hrk_pkg::RATE_W-1:0] optical_rate;
	logic [hrk_pkg::RATE_W-1:0] accel_rate;
	logic [hrk_pkg::MOTION_W-1:0] motion_level;
	logic [hrk_pkg::CONF_W-1:0] confidence;
	modport source(output valid, optical_rate, accel_rate, motion_level, confidence,
		input ready);
	modport sink(input valid, optical_rate, accel_rate, motion_level, confidence,
		output ready);
endinterface

interface hrk_out_if;
	logic valid;
	logic ready;
	logic [hrk_pkg::RATE_W-1:0] rate_estimate;
	logic [hrk_pkg::VAR_W-1:0] estimate_variance;
	logic updated;
	modport source(output valid, rate_estimate, estimate_variance, updated, input ready);
	modport sink(input valid, rate_estimate, estimate_variance, updated, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/hrk_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hrk_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [hrk_pkg::DIVD_W-1:0]   dividend,
	input  wire logic [hrk_pkg::DIVS_W-1:0]   divisor,
	output logic                              busy,
	output logic [hrk_pkg::DIVD_W-1:0]        quotient
);
	import hrk_pkg::*;

	localparam int CNT_W = $clog2(DIVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W:0] trial;
	logic take;

	// Restoring division, one quotient bit per cycle.
	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign take = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(DIVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? DIVS_W'(trial - {1'b0, dvs_q}) : trial[DIVS_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ----- rtl/core/hrk_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hrk_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire hrk_pkg::sts_t  sts,
	output hrk_pkg::cmd_t       cmd
);
	import hrk_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_GATE = 5'd1;
	localparam logic [4:0] S_MDELTA = 5'd2;
	localparam logic [4:0] S_DELTA = 5'd3;
	localparam logic [4:0] S_MSQ = 5'd4;
	localparam logic [4:0] S_DRO = 5'd5;
	localparam logic [4:0] S_CRO = 5'd7;
	localparam logic [4:0] S_MWO = 5'd8;
	localparam logic [4:0] S_MWA = 5'd9;
	localparam logic [4:0] S_MWS = 5'd10;
	localparam logic [4:0] S_SUM = 5'd11;
	localparam logic [4:0] S_NORM = 5'd12;
	localparam logic [4:0] S_SUM2 = 5'd13;
	localparam logic [4:0] S_CHK = 5'd14;
	localparam logic [4:0] S_DGO = 5'd15;
	localparam logic [4:0] S_WGO = 5'd16;
	localparam logic [4:0] S_CGO = 5'd17;
	localparam logic [4:0] S_DGA = 5'd18;
	localparam logic [4:0] S_WGA = 5'd19;
	localparam logic [4:0] S_CGA = 5'd20;
	localparam logic [4:0] S_DGS = 5'd21;
	localparam logic [4:0] S_WGS = 5'd22;
	localparam logic [4:0] S_CGS = 5'd23;
	localparam logic [4:0] S_MGX = 5'd24;
	localparam logic [4:0] S_MGO = 5'd25;
	localparam logic [4:0] S_MGA = 5'd26;
	localparam logic [4:0] S_COMMIT = 5'd27;
	localparam logic [4:0] S_PRED = 5'd28;
	localparam logic [4:0] S_OUT = 5'd29;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic out_valid_q;
	logic out_free;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		cmd.out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					state_d = S_GATE;
				end
			end
			S_GATE: state_d = sts.gate_ok ? S_MDELTA : S_PRED;
			S_MDELTA: begin cmd.op = OP_MDELTA; state_d = S_DELTA; end
			S_DELTA: begin cmd.op = OP_DELTA; state_d = S_MSQ; end
			S_MSQ: begin cmd.op = OP_MSQ; state_d = S_DRO; end
			S_DRO: begin cmd.op = OP_MRO; state_d = S_CRO; end
			S_CRO: begin cmd.op = OP_CAP_RO; state_d = S_MWO; end
			S_MWO: begin cmd.op = OP_MWO; state_d = S_MWA; end
			S_MWA: begin cmd.op = OP_MWA; state_d = S_MWS; end
			S_MWS: begin cmd.op = OP_MWS; state_d = S_SUM; end
			S_SUM: begin cmd.op = OP_SUM; state_d = S_NORM; end
			S_NORM: begin
				if (sts.norm_done) begin
					state_d = S_SUM2;
				end else begin
					cmd.op = OP_NORM;
				end
			end
			S_SUM2: begin cmd.op = OP_SUM; state_d = S_CHK; end
			S_CHK: state_d = sts.det_zero ? S_PRED : S_DGO;
			S_DGO: begin cmd.op = OP_DIV_GO; state_d = S_WGO; end
			S_WGO: if (!sts.div_busy) state_d = S_CGO;
			S_CGO: begin cmd.op = OP_CAP_GO; state_d = S_DGA; end
			S_DGA: begin cmd.op = OP_DIV_GA; state_d = S_WGA; end
			S_WGA: if (!sts.div_busy) state_d = S_CGA;
			S_CGA: begin cmd.op = OP_CAP_GA; state_d = S_DGS; end
			S_DGS: begin cmd.op = OP_DIV_GS; state_d = S_WGS; end
			S_WGS: if (!sts.div_busy) state_d = S_CGS;
			S_CGS: begin cmd.op = OP_CAP_GS; state_d = S_MGX; end
			S_MGX: begin cmd.op = OP_MGX; state_d = S_MGO; end
			S_MGO: begin cmd.op = OP_MGO; state_d = S_MGA; end
			S_MGA: begin cmd.op = OP_MGA; state_d = S_COMMIT; end
			S_COMMIT: begin cmd.op = OP_COMMIT; state_d = S_OUT; end
			S_PRED: begin cmd.op = OP_PRED; state_d = S_OUT; end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/hrk_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hrk_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire hrk_pkg::cmd_t                  cmd,
	output hrk_pkg::sts_t                       sts,
	input  wire logic                           cfg_we,
	input  wire logic [hrk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hrk_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [hrk_pkg::RATE_W-1:0]     optical_rate,
	input  wire logic [hrk_pkg::RATE_W-1:0]     accel_rate,
	input  wire logic [hrk_pkg::MOTION_W-1:0]   motion_level,
	input  wire logic [hrk_pkg::CONF_W-1:0]     confidence,
	output logic [hrk_pkg::RATE_W-1:0]          rate_estimate,
	output logic [hrk_pkg::VAR_W-1:0]           estimate_variance,
	output logic                                updated
);
	import hrk_pkg::*;

	localparam int W_W = 56;
	localparam int DET_W = 58;
	localparam int G_W = 33;
	localparam int ACC_W = 52;

	logic [MOTION_W-1:0] mt_low_q, mt_high_q;
	logic [CONF_W-1:0] gate_q;
	logic [RA_W-1:0] ra_q;

	logic [RATE_W-1:0] x_q;
	logic [VAR_W-1:0] p_q;
	logic upd_q;

	logic [RATE_W-1:0] zo_q, za_q;
	logic [CONF_W-1:0] conf_q;
	logic [VAR_W-1:0] pp_q;
	logic [DET_W-1:0] prod_q;
	logic [28:0] d25_q;
	logic [63:0] ro_prod_q;
	logic [RA_W-1:0] ro_q;
	logic [W_W-1:0] wo_q, wa_q, ws_q;
	logic [DET_W-1:0] det_q;
	logic [G_W-1:0] go_q, ga_q, gs_q;
	logic [ACC_W-1:0] acc_q;

	logic [RATE_W-1:0] out_rate_q;
	logic [VAR_W-1:0] out_var_q;
	logic out_upd_q;

	logic [VAR_W-1:0] q_sel;
	logic [VAR_W:0] pp_sum;
	logic [CONF_W-1:0] conf_in, conf_f, conf_inv;
	logic [23:0] delta;
	logic [28:0] d25;
	logic [56:0] ro_num;
	logic [32:0] ro_m;
	logic [66:0] ro_sum;
	logic [G_W-1:0] gx;
	logic [32:0] ma;
	logic [31:0] mb;
	logic [64:0] prod;
	logic [64:0] var_sum;
	logic [19:0] est;

	logic div_start;
	logic [DIVD_W-1:0] div_dvd;
	logic [DIVS_W-1:0] div_dvs;
	logic div_busy;
	logic [DIVD_W-1:0] div_quo;

	always_comb begin
		if (motion_level <= mt_low_q) begin
			q_sel = Q_LOW;
		end else if (motion_level <= mt_high_q) begin
			q_sel = Q_MID;
		end else begin
			q_sel = Q_HIGH;
		end
	end

	assign pp_sum = {1'b0, p_q} + {1'b0, q_sel};
	assign conf_in = (confidence > CONF_ONE) ? CONF_ONE : confidence;
	assign conf_f = (conf_q < CONF_FLOOR) ? CONF_FLOOR : conf_q;
	assign conf_inv = CONF_ONE - conf_f;

	assign delta = DELTA_BASE + 24'((prod_q[39:0] + 40'd32768) >> 16);
	assign d25 = {delta, 4'b0} + {2'b0, delta, 3'b0} + {5'b0, delta};

	// Optical noise: the rounded numerator without its low 24 bits is divided
	// by 2401 through the reciprocal. The low part of the reciprocal goes
	// through the multiplier, the factor 3 of the high part is a shift-add.
	assign ro_num = prod_q[56:0] + RO_BIAS;
	assign ro_m = ro_num[56:24];
	assign ro_sum = 67'(ro_prod_q) + {(35'(ro_m) << 1) + 35'(ro_m), 32'b0};

	assign gx = 33'h1_0000_0000 - go_q - ga_q;

	// Shared multiplier; every product is registered before further use.
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_MDELTA: begin ma = 33'(conf_inv); mb = 32'(DELTA_SPAN); end
			OP_MSQ: begin ma = 33'(d25_q); mb = 32'(d25_q); end
			OP_MRO: begin ma = ro_m; mb = RO_RECIP_LO; end
			OP_MWO: begin ma = 33'(pp_q); mb = 32'(ra_q); end
			OP_MWA: begin ma = 33'(pp_q); mb = 32'(ro_q); end
			OP_MWS: begin ma = 33'(ro_q); mb = 32'(ra_q); end
			OP_MGX: begin ma = gx; mb = 32'(x_q); end
			OP_MGO: begin ma = go_q; mb = 32'(zo_q); end
			OP_MGA: begin ma = ga_q; mb = 32'(za_q); end
			OP_COMMIT: begin ma = gs_q; mb = pp_q; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign prod = 65'(ma) * 65'(mb);
	assign var_sum = prod + 65'h8000_0000;
	assign est = acc_q[ACC_W-1:32];

	always_comb begin
		div_start = 1'b0;
		div_dvd = '0;
		div_dvs = {5'b0, det_q[30:0]};
		case (cmd.op)
			OP_DIV_GO: begin div_start = 1'b1; div_dvd = {wo_q[31:0], 32'b0}; end
			OP_DIV_GA: begin div_start = 1'b1; div_dvd = {wa_q[31:0], 32'b0}; end
			OP_DIV_GS: begin div_start = 1'b1; div_dvd = {ws_q[31:0], 32'b0}; end
			default: div_start = 1'b0;
		endcase
	end

	hrk_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mt_low_q <= MOTION_LOW_RST;
			mt_high_q <= MOTION_HIGH_RST;
			gate_q <= CONF_GATE_RST;
			ra_q <= ACCEL_NOISE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MOTION_LOW: mt_low_q <= cfg_data[MOTION_W-1:0];
				REG_MOTION_HIGH: mt_high_q <= cfg_data[MOTION_W-1:0];
				REG_CONF_GATE: gate_q <= cfg_data[CONF_W-1:0];
				REG_ACCEL_NOISE: ra_q <= cfg_data[RA_W-1:0];
				default: ra_q <= ra_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= RATE_RST;
			p_q <= VAR_RST;
			upd_q <= 1'b0;
		end else if (cmd.op == OP_PRED) begin
			p_q <= pp_q;
			upd_q <= 1'b0;
		end else if (cmd.op == OP_COMMIT) begin
			p_q <= var_sum[63:32];
			x_q <= est[19] ? {RATE_W{1'b1}} : est[RATE_W-1:0];
			upd_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				zo_q <= optical_rate;
				za_q <= accel_rate;
				conf_q <= conf_in;
				pp_q <= pp_sum[VAR_W] ? {VAR_W{1'b1}} : pp_sum[VAR_W-1:0];
			end
			OP_MDELTA, OP_MSQ: prod_q <= prod[DET_W-1:0];
			OP_DELTA: d25_q <= d25;
			OP_MRO: ro_prod_q <= prod[63:0];
			OP_CAP_RO: ro_q <= RA_W'(ro_sum[66:45]);
			OP_MWO: wo_q <= prod[W_W-1:0];
			OP_MWA: wa_q <= prod[W_W-1:0];
			OP_MWS: ws_q <= prod[W_W-1:0];
			OP_SUM: det_q <= DET_W'(wo_q) + DET_W'(wa_q) + DET_W'(ws_q);
			OP_NORM: begin
				det_q <= det_q >> 1;
				wo_q <= wo_q >> 1;
				wa_q <= wa_q >> 1;
				ws_q <= ws_q >> 1;
			end
			OP_CAP_GO: go_q <= div_quo[G_W-1:0];
			OP_CAP_GA: ga_q <= div_quo[G_W-1:0];
			OP_CAP_GS: gs_q <= div_quo[G_W-1:0];
			OP_MGX: acc_q <= prod[ACC_W-1:0] + ACC_W'(64'h8000_0000);
			OP_MGO, OP_MGA: acc_q <= acc_q + prod[ACC_W-1:0];
			default: acc_q <= acc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_rate_q <= x_q;
			out_var_q <= p_q;
			out_upd_q <= upd_q;
		end
	end

	assign sts.gate_ok = conf_q >= gate_q;
	assign sts.norm_done = (det_q[DET_W-1:31] == '0);
	assign sts.det_zero = (det_q == '0);
	assign sts.div_busy = div_busy;

	assign rate_estimate = out_rate_q;
	assign estimate_variance = out_var_q;
	assign updated = out_upd_q;

endmodule

`default_nettype wire

// ----- rtl/core/heart_rate_kalman_two_sensor_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Scalar Kalman filter that fuses an optical and an accelerometer-derived heart
// rate once per window. Each input beat predicts first (the variance grows by a
// process noise picked from three levels by motion_level) and, when the clamped
// confidence reaches confidence_gate, fuses both measurements into a new rate
// estimate and variance; otherwise, or if the gain denominator is zero, the
// estimate is held and updated reads 0. One input beat gives exactly one
// result beat. A beat under the gate runs through the gate, predict and output
// states only. A fused beat's time is set mostly by three passes through one
// shared restoring divider at one quotient bit per cycle, each with start and
// capture, by up to 27 normalization shifts of the gain denominator, and by
// ten products on the single shared 33x32 multiplier. The optical noise divides
// by a constant, done by a reciprocal multiply rather than the divider.
// The block takes one item at a time; a finished result sits in an output
// register, so a new input beat is accepted as soon as the sequencer is idle
// even if the last result has not been taken, and that next item then waits
// at its end for as long as the old result is stalled. Configuration registers
// are written through cfg_we, cfg_index and cfg_data and should only change
// while no item is in flight.

module heart_rate_kalman_two_sensor_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	hrk_in_if.sink                              sample,
	hrk_out_if.source                           result,
	input  wire logic                           cfg_we,
	input  wire logic [hrk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hrk_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hrk_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The controller sequences the steps; the datapath owns all arithmetic,
	// the filter state and the result register.
	hrk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hrk_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.optical_rate      (sample.optical_rate),
		.accel_rate        (sample.accel_rate),
		.motion_level      (sample.motion_level),
		.confidence        (sample.confidence),
		.rate_estimate     (result.rate_estimate),
		.estimate_variance (result.estimate_variance),
		.updated           (result.updated)
	);

endmodule

`default_nettype wire

// ----- rtl/core/hrk_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hrk_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [18:0] rate_estimate,
	input wire logic [31:0] estimate_variance,
	input wire logic        updated
);

	// A stalled result beat holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rate_estimate)
			&& $stable(estimate_variance) && $stable(updated))
		else $error("stalled result beat changed");

	// One item at a time: the sequencer is busy right after an accept.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	// No result can appear in the cycle after an accept.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	// A prediction-only step always adds at least the smallest process noise.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !updated |-> estimate_variance >= 32'd6711)
		else $error("predicted variance below process noise floor");

endmodule

bind heart_rate_kalman_two_sensor_core hrk_checker u_hrk_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (sample.valid),
	.in_ready          (sample.ready),
	.out_valid         (result.valid),
	.out_ready         (result.ready),
	.rate_estimate     (result.rate_estimate),
	.estimate_variance (result.estimate_variance),
	.updated           (result.updated)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import hrk_pkg::*;

	// One input beat of the filter: two rate measurements, the motion level
	// that picks the process noise and the optical confidence.
	typedef struct {
		logic [RATE_W-1:0]   optical_rate;
		logic [RATE_W-1:0]   accel_rate;
		logic [MOTION_W-1:0] motion_level;
		logic [CONF_W-1:0]   confidence;
	} window_t;

	// One result beat as the filter should produce it.
	typedef struct {
		logic [RATE_W-1:0] rate_estimate;
		logic [VAR_W-1:0]  estimate_variance;
		logic              updated;
	} estimate_t;

	// The scoreboard keeps its own copy of the filter state and registers,
	// predicts each estimate when a window is accepted and holds it until
	// the matching result beat shows up.
	class kalman_scoreboard;
		logic [MOTION_W-1:0] thr_low;
		logic [MOTION_W-1:0] thr_high;
		logic [CONF_W-1:0]   gate;
		logic [RA_W-1:0]     accel_var;
		logic [RATE_W-1:0]   rate_q;
		logic [VAR_W-1:0]    var_q;
		estimate_t           pending_estimates[$];
		int                  mismatches;

		function new();
			thr_low = MOTION_LOW_RST;
			thr_high = MOTION_HIGH_RST;
			gate = CONF_GATE_RST;
			accel_var = ACCEL_NOISE_RST;
			rate_q = RATE_RST;
			var_q = VAR_RST;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_MOTION_LOW: thr_low = data[MOTION_W-1:0];
				REG_MOTION_HIGH: thr_high = data[MOTION_W-1:0];
				REG_CONF_GATE: gate = data[CONF_W-1:0];
				REG_ACCEL_NOISE: accel_var = data[RA_W-1:0];
				default: ;
			endcase
		endfunction

		// Optical noise variance in Q0.24 from the clamped confidence.
		function logic [63:0] optical_var(logic [63:0] c);
			logic [63:0] cc;
			logic [63:0] delta;
			logic [63:0] den;
			cc = (c < 64'(CONF_FLOOR)) ? 64'(CONF_FLOOR) : c;
			delta = 64'(DELTA_BASE) +
				(((64'(CONF_ONE) - cc) * 64'(DELTA_SPAN) + 64'd32768) >> 16);
			den = 64'd38416 << 24;
			return (delta * delta * 64'd10000 + den / 2) / den;
		endfunction

		function void note_window(window_t w);
			logic [63:0] c, p, r_o, r_a, w_o, w_a, w_s, det, g_o, g_a, g_s, g_x, acc;
			logic [63:0] qn;
			estimate_t e;
			int s;
			c = 64'(w.confidence);
			if (c > 64'(CONF_ONE))
				c = 64'(CONF_ONE);
			if (w.motion_level <= thr_low)
				qn = 64'(Q_LOW);
			else if (w.motion_level <= thr_high)
				qn = 64'(Q_MID);
			else
				qn = 64'(Q_HIGH);
			p = 64'(var_q) + qn;
			if (p > 64'hFFFF_FFFF)
				p = 64'hFFFF_FFFF;
			e.updated = 1'b0;
			var_q = p[31:0];
			if (c >= 64'(gate)) begin
				r_o = optical_var(c);
				r_a = 64'(accel_var);
				w_o = p * r_a;
				w_a = p * r_o;
				w_s = r_o * r_a;
				det = w_o + w_a + w_s;
				s = 0;
				while (s < 63 && (det >> s) >= (64'd1 << 31))
					s++;
				w_o = w_o >> s;
				w_a = w_a >> s;
				w_s = w_s >> s;
				det = w_o + w_a + w_s;
				if (det != 0) begin
					g_o = (w_o << 32) / det;
					g_a = (w_a << 32) / det;
					g_s = (w_s << 32) / det;
					g_x = (64'd1 << 32) - g_o - g_a;
					acc = 64'(rate_q) * g_x + 64'(w.optical_rate) * g_o +
						64'(w.accel_rate) * g_a + (64'd1 << 31);
					acc = acc >> 32;
					if (acc > 64'h7FFFF)
						acc = 64'h7FFFF;
					rate_q = acc[RATE_W-1:0];
					acc = (p * g_s + (64'd1 << 31)) >> 32;
					var_q = acc[31:0];
					e.updated = 1'b1;
				end
			end
			e.rate_estimate = rate_q;
			e.estimate_variance = var_q;
			pending_estimates.push_back(e);
		endfunction

		function void check_estimate(estimate_t got);
			estimate_t want;
			if (pending_estimates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: rate %0d var %0d upd %0b",
						got.rate_estimate, got.estimate_variance, got.updated);
				return;
			end
			want = pending_estimates.pop_front();
			if (got.rate_estimate !== want.rate_estimate ||
					got.estimate_variance !== want.estimate_variance ||
					got.updated !== want.updated) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: rate %0d/%0d var %0d/%0d upd %0b/%0b (exp/act)",
						want.rate_estimate, got.rate_estimate,
						want.estimate_variance, got.estimate_variance,
						want.updated, got.updated);
			end
		endfunction
	endclass

	localparam int IDLE_LIMIT = 20000;
	localparam int LONG_HOLD = 3000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hrk_in_if sample();
	hrk_out_if result();

	heart_rate_kalman_two_sensor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample.sink),
		.result(result.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	kalman_scoreboard sb;
	int idle_cycles;
	bit long_hold_req;
	int burst_left;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Both sides are sampled at the rising edge, before the block updates.
	// The watchdog counts cycles in which no beat moves on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			estimate_t got;
			window_t w;
			if (sample.valid && sample.ready) begin
				w.optical_rate = sample.optical_rate;
				w.accel_rate = sample.accel_rate;
				w.motion_level = sample.motion_level;
				w.confidence = sample.confidence;
				sb.note_window(w);
			end
			if (result.valid && result.ready) begin
				got.rate_estimate = result.rate_estimate;
				got.estimate_variance = result.estimate_variance;
				got.updated = result.updated;
				sb.check_estimate(got);
			end
			if ((sample.valid && sample.ready) || (result.valid && result.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Receiver: stalls in modes that change now and then, including stretches
	// with no stall at all. A long hold-off request keeps ready low so the
	// single-item block backs up into its input.
	initial begin
		int mode;
		int mode_left;
		int hold;
		result.ready = 1'b0;
		mode = 0;
		mode_left = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				result.ready = 1'b0;
				for (hold = 1; hold < LONG_HOLD; hold++)
					@(negedge clk);
				long_hold_req = 1'b0;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 400);
			end
			mode_left--;
			case (mode)
				0: result.ready = 1'b1;
				1: result.ready = ($urandom_range(0, 3) != 0);
				2: result.ready = ($urandom_range(0, 3) == 0);
				default: result.ready = ($urandom_range(0, 40) == 0);
			endcase
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic configure(int lo, int hi, int g, int ra);
		write_reg(REG_MOTION_LOW, CFG_DATA_W'(lo));
		write_reg(REG_MOTION_HIGH, CFG_DATA_W'(hi));
		write_reg(REG_CONF_GATE, CFG_DATA_W'(g));
		write_reg(REG_ACCEL_NOISE, CFG_DATA_W'(ra));
	endtask

	// Offers one window and holds it until it is accepted. The sender works
	// in bursts; between bursts valid may drop for a random gap.
	task automatic send_window(window_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				@(negedge clk);
				sample.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		sample.valid = 1'b1;
		sample.optical_rate = w.optical_rate;
		sample.accel_rate = w.accel_rate;
		sample.motion_level = w.motion_level;
		sample.confidence = w.confidence;
		do
			@(posedge clk);
		while (!sample.ready);
	endtask

	task automatic send_fields(int zo, int za, int m, int c);
		window_t w;
		w.optical_rate = RATE_W'(zo);
		w.accel_rate = RATE_W'(za);
		w.motion_level = MOTION_W'(m);
		w.confidence = CONF_W'(c);
		send_window(w);
	endtask

	// Drops valid, then waits until every predicted estimate has come back.
	task automatic wait_drained();
		int guard;
		@(negedge clk);
		sample.valid = 1'b0;
		guard = 0;
		while (sb.pending_estimates.size() != 0 && guard < 10 * IDLE_LIMIT) begin
			@(negedge clk);
			guard++;
		end
		repeat (10) @(negedge clk);
	endtask

	// Mostly plausible heart rates (0.5 to 3.5 Hz) with motion near the
	// thresholds and confidence spread around the gate; the rest is raw noise
	// over the full width of every field.
	task automatic send_random(int n);
		window_t w;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 80) begin
				w.optical_rate = RATE_W'($urandom_range(32768, 229376));
				w.accel_rate = RATE_W'(int'(w.optical_rate) + $urandom_range(0, 16384) - 8192);
				w.motion_level = MOTION_W'($urandom_range(0, 16000));
				w.confidence = CONF_W'($urandom_range(0, 65536));
			end else begin
				w.optical_rate = RATE_W'($urandom);
				w.accel_rate = RATE_W'($urandom);
				w.motion_level = MOTION_W'($urandom);
				w.confidence = CONF_W'($urandom);
			end
			send_window(w);
		end
	endtask

	initial begin
		sb = new();
		idle_cycles = 0;
		long_hold_req = 1'b0;
		burst_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample.valid = 1'b0;
		sample.optical_rate = '0;
		sample.accel_rate = '0;
		sample.motion_level = '0;
		sample.confidence = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed part on the reset register values: motion exactly on and
		// just past each threshold, rate extremes, confidence at zero, exactly
		// on and just under the gate, at one and above one.
		send_fields(65536, 65536, 0, 65536);
		send_fields(0, 0, 8500, 65536);
		send_fields(524287, 524287, 8501, 65536);
		send_fields(524287, 0, 11000, 131071);
		send_fields(0, 524287, 11001, 100000);
		send_fields(100000, 90000, 65535, 19661);
		send_fields(100000, 90000, 65535, 19660);
		send_fields(70000, 72000, 5000, 0);
		wait_drained();

		// Gate at zero: every window fuses, so a confidence of zero, one
		// under the floor and the floor itself all reach the noise formula.
		// Accelerometer noise at zero pins the estimate to the accel rate.
		configure(0, 65535, 0, 0);
		send_fields(80000, 60000, 0, 0);
		send_fields(80000, 60000, 1, 65);
		send_fields(80000, 60000, 65535, 66);
		send_fields(524287, 524287, 0, 131071);
		wait_drained();
		configure(0, 0, 0, 16777215);
		send_fields(0, 524287, 0, 0);
		send_fields(524287, 0, 1, 65536);
		send_fields(300000, 200000, 65535, 33000);
		send_random(60);
		wait_drained();

		// A gate above one: the filter only ever predicts.
		configure(65535, 65535, 100000, 272956);
		send_fields(200000, 200000, 65535, 131071);
		send_fields(200000, 200000, 0, 65536);
		send_random(60);
		wait_drained();

		// Low threshold above the high one, gate at exactly one.
		configure(12000, 9000, 65536, 5000);
		send_fields(150000, 140000, 10000, 65536);
		send_fields(150000, 140000, 12001, 65535);
		send_random(80);
		wait_drained();

		// Reset values again, with a long receiver hold-off while the
		// sender keeps offering windows.
		configure(8500, 11000, 19661, 272956);
		long_hold_req = 1'b1;
		send_random(300);
		wait_drained();

		// Random register settings.
		for (int ph = 0; ph < 4; ph++) begin
			configure($urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65536), $urandom_range(0, 16777215));
			send_random(90);
			wait_drained();
		end
		repeat (400) @(negedge clk);

		if (sb.mismatches == 0 && sb.pending_estimates.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
